>>> hw/rtl/fzf_pkg.sv
package fzf_pkg;

  // Field and port widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DEG_W    = 16;
  localparam int unsigned QUO_W    = 15;
  localparam int unsigned SET_W    = 2;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned BREAK_W  = 64;
  localparam int unsigned MODE_W   = 8;

  // Divider pipeline: a few quotient bits per stage
  localparam int unsigned BITS_PER_STAGE = 3;
  localparam int unsigned DIV_STAGES     = QUO_W / BITS_PER_STAGE;

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  // Register indexes above the breakpoint registers
  localparam logic [ADDR_W-1:0] REG_SHOULDER = 3'd4;
  localparam logic [ADDR_W-1:0] REG_SETS     = 3'd5;

  // Shoulder codes
  localparam logic [1:0] SH_LEFT  = 2'd1;
  localparam logic [1:0] SH_RIGHT = 2'd2;

  localparam logic [CNT_W-1:0] SETS_RESET = 3'd4;
  localparam logic [DEG_W-1:0] DEG_ONE    = 16'h8000;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_ONE,
    KIND_DIV
  } kind_e;

  // One degree job: rem/den/quo carry the running fraction division
  typedef struct packed {
    logic [SET_W-1:0] set_index;
    logic             last;
    kind_e            kind;
    logic [DEG_W-1:0] rem;
    logic [DEG_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } job_t;

  // Restoring division, BITS_PER_STAGE quotient bits; rem stays below den
  function automatic job_t div_step(job_t j);
    job_t           r;
    logic [DEG_W:0] shifted;
    logic [DEG_W:0] trial;
    r = j;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      shifted = {r.rem, 1'b0};
      trial   = shifted - {1'b0, r.den};
      if (shifted >= {1'b0, r.den}) begin
        r.rem = trial[DEG_W-1:0];
        r.quo = {r.quo[QUO_W-2:0], 1'b1};
      end else begin
        r.rem = shifted[DEG_W-1:0];
        r.quo = {r.quo[QUO_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/fuzzy_trapezoid_fuzzifier_unit.sv
// Degree jobs pass the job queue, the divider stages and the output register.
// Throughput: one degree per cycle unless the queue is full or the output stalls;
// a sample gives sets_in_use degrees (1 to 4), one fuzzy set classified per cycle.
// Slopes run through a 5-stage divider pipeline, 3 quotient bits per stage.
// Reset: breakpoints clear to 0, no shoulders, four sets in use, the job queue empty.
module fuzzy_trapezoid_fuzzifier_unit #(
  parameter int unsigned NUM_SETS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fzf_pkg::ADDR_W-1:0]          cfg_addr_i,
  input  logic [fzf_pkg::BREAK_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [fzf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fzf_pkg::SET_W-1:0]           set_index_o,
  output logic [fzf_pkg::DEG_W-1:0]           degree_o,
  output logic                                last_o
);

  logic [NUM_SETS-1:0][fzf_pkg::BREAK_W-1:0] breaks_q;
  logic [fzf_pkg::MODE_W-1:0]                modes_q;
  logic [fzf_pkg::CNT_W-1:0]                 sets_q;

  logic          push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  fzf_pkg::job_t push_job;
  fzf_pkg::job_t q_head;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      breaks_q <= '0;
      modes_q  <= '0;
      sets_q   <= fzf_pkg::SETS_RESET;
    end else if (cfg_we_i) begin
      for (int g = 0; g < NUM_SETS; g++) begin
        if (cfg_addr_i == fzf_pkg::ADDR_W'(g)) begin
          breaks_q[g] <= cfg_wdata_i;
        end
      end
      if (cfg_addr_i == fzf_pkg::REG_SHOULDER) begin
        modes_q <= cfg_wdata_i[fzf_pkg::MODE_W-1:0];
      end
      if (cfg_addr_i == fzf_pkg::REG_SETS) begin
        sets_q <= cfg_wdata_i[fzf_pkg::CNT_W-1:0];
      end
    end
  end

  fzf_front #(
    .NUM_SETS (NUM_SETS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .breaks_i   (breaks_q),
    .modes_i    (modes_q),
    .sets_i     (sets_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  fzf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  fzf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .set_index_o (set_index_o),
    .degree_o    (degree_o),
    .last_o      (last_o)
  );

endmodule

>>> hw/rtl/fzf_front.sv
module fzf_front #(
  parameter int unsigned NUM_SETS = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [fzf_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic [NUM_SETS-1:0][fzf_pkg::BREAK_W-1:0] breaks_i,
  input  logic [fzf_pkg::MODE_W-1:0]            modes_i,
  input  logic [fzf_pkg::CNT_W-1:0]             sets_i,
  input  logic                                  q_full_i,
  output logic                                  push_o,
  output fzf_pkg::job_t                         job_o
);

  logic                                busy_q;
  logic [fzf_pkg::SET_W-1:0]           cnt_q;
  logic [fzf_pkg::CNT_W-1:0]           n_q;
  logic signed [fzf_pkg::SAMPLE_W-1:0] sample_q;

  logic [fzf_pkg::CNT_W-1:0]           n_eff;
  logic [fzf_pkg::BREAK_W-1:0]         brk;
  logic [1:0]                          mode;
  logic signed [fzf_pkg::SAMPLE_W-1:0] x, a, b, c, d;
  logic [fzf_pkg::SAMPLE_W:0]          rise_num, rise_den, fall_num, fall_den;
  logic                                is_last;
  logic                                accept;

  // Clamp the set count into 1..NUM_SETS
  always_comb begin
    if (sets_i == '0) begin
      n_eff = fzf_pkg::CNT_W'(1);
    end else if (sets_i > fzf_pkg::CNT_W'(NUM_SETS)) begin
      n_eff = fzf_pkg::CNT_W'(NUM_SETS);
    end else begin
      n_eff = sets_i;
    end
  end

  // Pick the breakpoints of the current set
  always_comb begin
    brk = '0;
    for (int g = 0; g < NUM_SETS; g++) begin
      if (cnt_q == fzf_pkg::SET_W'(g)) begin
        brk = breaks_i[g];
      end
    end
  end

  assign mode = modes_i[{cnt_q, 1'b0} +: 2];
  assign x    = sample_q;
  assign a    = brk[15:0];
  assign b    = brk[31:16];
  assign c    = brk[47:32];
  assign d    = brk[63:48];

  assign rise_num = {x[15], x} - {a[15], a};
  assign rise_den = {b[15], b} - {a[15], a};
  assign fall_num = {d[15], d} - {x[15], x};
  assign fall_den = {d[15], d} - {c[15], c};

  assign is_last = ({1'b0, cnt_q} + fzf_pkg::CNT_W'(1)) == n_q;

  // Classify the sample against the current set
  always_comb begin
    job_o           = '0;
    job_o.set_index = cnt_q;
    job_o.last      = is_last;
    job_o.kind      = fzf_pkg::KIND_ONE;
    if (mode == fzf_pkg::SH_LEFT && x < b) begin
      job_o.kind = fzf_pkg::KIND_ONE;
    end else if (mode == fzf_pkg::SH_RIGHT && x > c) begin
      job_o.kind = fzf_pkg::KIND_ONE;
    end else if (x < a || x > d) begin
      job_o.kind = fzf_pkg::KIND_ZERO;
    end else if (x < b) begin
      job_o.kind = fzf_pkg::KIND_DIV;
      job_o.rem  = rise_num[fzf_pkg::DEG_W-1:0];
      job_o.den  = rise_den[fzf_pkg::DEG_W-1:0];
    end else if (x > c) begin
      job_o.kind = fzf_pkg::KIND_DIV;
      job_o.rem  = fall_num[fzf_pkg::DEG_W-1:0];
      job_o.den  = fall_den[fzf_pkg::DEG_W-1:0];
    end
  end

  // Emit one set per cycle while the queue has room
  assign push_o     = busy_q && !q_full_i;
  assign in_stall_o = busy_q && !(push_o && is_last);
  assign accept     = in_valid_i && !in_stall_o;

  // Advance the set sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      n_q    <= fzf_pkg::SETS_RESET;
    end else if (accept) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      n_q    <= n_eff;
    end else if (push_o && is_last) begin
      busy_q <= 1'b0;
    end else if (push_o) begin
      cnt_q <= cnt_q + fzf_pkg::SET_W'(1);
    end
  end

  // Hold the sample for all of its sets
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
  end

endmodule

>>> hw/rtl/fzf_queue.sv
module fzf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fzf_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output fzf_pkg::job_t head_o
);

  fzf_pkg::job_t               mem_q [fzf_pkg::QUEUE_DEPTH];
  logic [fzf_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [fzf_pkg::QPTR_W:0]    count_q;
  logic                        do_push, do_pop;

  assign full_o  = count_q == (fzf_pkg::QPTR_W + 1)'(fzf_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + fzf_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + fzf_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (fzf_pkg::QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (fzf_pkg::QPTR_W + 1)'(1);
      end
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> hw/rtl/fzf_back.sv
module fzf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  fzf_pkg::job_t              q_head_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [fzf_pkg::SET_W-1:0]  set_index_o,
  output logic [fzf_pkg::DEG_W-1:0]  degree_o,
  output logic                       last_o
);

  fzf_pkg::job_t                     pipe_q [fzf_pkg::DIV_STAGES];
  logic [fzf_pkg::DIV_STAGES-1:0]    pv_q;
  logic                              out_valid_q;
  logic [fzf_pkg::SET_W-1:0]         set_index_q;
  logic [fzf_pkg::DEG_W-1:0]         degree_q;
  logic                              last_q;
  logic [fzf_pkg::DEG_W-1:0]         degree_d;
  logic                              en;

  // Move the whole pipe when the output register frees up
  assign en      = !out_valid_q || !out_stall_i;
  assign q_pop_o = en && q_valid_i;

  // Map the finished job to its degree
  always_comb begin
    case (pipe_q[fzf_pkg::DIV_STAGES-1].kind)
      fzf_pkg::KIND_ONE: degree_d = fzf_pkg::DEG_ONE;
      fzf_pkg::KIND_DIV: degree_d = {1'b0, pipe_q[fzf_pkg::DIV_STAGES-1].quo};
      default:           degree_d = '0;
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      pv_q        <= {pv_q[fzf_pkg::DIV_STAGES-2:0], q_valid_i};
      out_valid_q <= pv_q[fzf_pkg::DIV_STAGES-1];
    end
  end

  // Advance division stages and the output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q[0] <= fzf_pkg::div_step(q_head_i);
      for (int s = 1; s < fzf_pkg::DIV_STAGES; s++) begin
        pipe_q[s] <= fzf_pkg::div_step(pipe_q[s-1]);
      end
      set_index_q <= pipe_q[fzf_pkg::DIV_STAGES-1].set_index;
      last_q      <= pipe_q[fzf_pkg::DIV_STAGES-1].last;
      degree_q    <= degree_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign set_index_o = set_index_q;
  assign degree_o    = degree_q;
  assign last_o      = last_q;

endmodule
